// ===== rtl/core/transpose_cache_directory_unit_macros.svh =====
// Assertion macros for the transpose cache directory.
// Used by the top level; expects a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef TRANSPOSE_CACHE_DIRECTORY_UNIT_MACROS_SVH
`define TRANSPOSE_CACHE_DIRECTORY_UNIT_MACROS_SVH

// Property checked at every rising edge, switched off while reset is held.
`define TCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent, switched off while reset is held.
`define TCD_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/core/tcd_pkg.sv =====
// Shared types and constants of the transpose cache directory.
// No dependencies; imported by every other file of the block but the assertion macro header.
package tcd_pkg;

    localparam int ENTRIES    = 512;
    localparam int INDEX_BITS = 24;

    localparam int TABLE_W = 3;
    localparam int FIELD_W = 24;
    localparam int MODE_W  = 2;
    localparam int CAP_W   = 10;
    localparam int FSLOT_W = 9;
    localparam int CNT_W   = 32;

    // Stored index width: the key is compared in its low INDEX_BITS bits.
    localparam int IDX_W  = (INDEX_BITS < FIELD_W) ? INDEX_BITS : FIELD_W;
    localparam int SLOT_W = $clog2(ENTRIES);
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(512);

    typedef enum logic [MODE_W-1:0] {
        MODE_ACCESS = 2'd0,
        MODE_PROBE  = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef struct packed {
        logic [TABLE_W-1:0] tbl;
        logic [IDX_W-1:0]   idx;
    } t_entry;

    typedef struct packed {
        logic cmp_en;
        logic in_use;
        logic take_prev;
        logic take_next;
    } t_cell_ctl;

endpackage

// ===== rtl/core/tcd_if.sv =====
// Valid/ready channel interfaces for requests and responses of the directory.
// Depends on tcd_pkg for the field widths.
interface tcd_req_if
    import tcd_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [TABLE_W-1:0]   table_id;
    logic [FIELD_W-1:0]   entry_index;

    modport source (output valid, mode, table_id, entry_index, input ready);
    modport sink   (input valid, mode, table_id, entry_index, output ready);
endinterface

interface tcd_rsp_if
    import tcd_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [FSLOT_W-1:0]   found_slot;
    logic                 evicted;
    logic [TABLE_W-1:0]   evicted_table;
    logic [FIELD_W-1:0]   evicted_index;
    logic [CNT_W-1:0]     requests;
    logic [CNT_W-1:0]     hits;

    modport source (output valid, found, found_slot, evicted, evicted_table,
                    evicted_index, requests, hits, input ready);
    modport sink   (input valid, found, found_slot, evicted, evicted_table,
                    evicted_index, requests, hits, output ready);
endinterface

// ===== rtl/core/tcd_cell.sv =====
// One directory slot: holds a key, compares it and moves it to or from its neighbours.
// Depends on tcd_pkg.
module tcd_cell
    import tcd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_key,
    input  t_entry    i_prev,
    input  t_entry    i_next,
    output t_entry    o_data,
    output logic      o_match
);

    t_entry r_data;
    logic   r_match;

    always_ff @(posedge i_clk) begin
        if (i_ctl.take_prev) begin
            r_data <= i_prev;
        end else if (i_ctl.take_next) begin
            r_data <= i_next;
        end
    end

    // The match is only meaningful for a slot that is in use.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.cmp_en) begin
            r_match <= i_ctl.in_use && (r_data == i_key);
        end
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

// ===== rtl/core/tcd_reduce.sv =====
// Folds the row of slot flags into the hit slot number and the key of the last slot.
// Depends on tcd_pkg.
module tcd_reduce
    import tcd_pkg::*;
(
    input  logic [ENTRIES-1:0] i_match,
    input  logic [ENTRIES-1:0] i_last,
    input  t_entry             i_data [ENTRIES],
    output logic               o_found,
    output logic [SLOT_W-1:0]  o_slot,
    output t_entry             o_last_data
);

    // At most one slot matches and exactly one is last, so plain OR trees do.
    always_comb begin
        o_found     = |i_match;
        o_slot      = '0;
        o_last_data = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_match[i]) begin
                o_slot = o_slot | SLOT_W'(i);
            end
            if (i_last[i]) begin
                o_last_data = o_last_data | i_data[i];
            end
        end
    end

endmodule

// ===== rtl/core/transpose_cache_directory_unit.sv =====
// Transpose cache directory: each cell registers its key compare as a request beat is accepted;
// the row shift or swap and the counter update are made as the response enters the output register,
// which waits while that register is full. No new request is taken before that.
// Reset (synchronous, active low) empties the directory, zeroes both counters and sets the
// capacity limit to 512; slot contents are left as they are and need no clearing pass.
module transpose_cache_directory_unit
    import tcd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    tcd_req_if.sink          i_req,
    tcd_rsp_if.source        o_rsp
);

`include "transpose_cache_directory_unit_macros.svh"

    // Two-state sequencer. In S_IDLE a request beat is taken and every cell compares its key
    // with the request at the same edge. In S_UPD the registered matches are folded, the row
    // is updated and the response is written into the output register as soon as it is free.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_UPD  = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic [CAP_W-1:0] r_cap;
    logic [OCC_W-1:0] r_occ, n_occ;
    logic [CNT_W-1:0] r_reqs, n_reqs;
    logic [CNT_W-1:0] r_hits, n_hits;
    t_mode            r_mode;
    t_entry           r_key;

    logic             r_out_valid;
    logic             r_out_found;
    logic [FSLOT_W-1:0] r_out_slot;
    logic             r_out_ev;
    t_entry           r_out_ev_data;

    logic req_accept;
    logic commit;
    logic is_access;
    t_entry in_key;

    // Effective limit: the register value clamped to one up to the number of slots.
    logic [CMP_W-1:0]  cap_wide;
    logic [OCC_W-1:0]  lim;
    logic [SLOT_W-1:0] lim_m1;
    logic              evict;

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] last_sel;
    t_entry             cell_data [ENTRIES];
    t_cell_ctl          cell_ctl  [ENTRIES];

    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    t_entry            last_data;

    assign in_key.tbl = i_req.table_id;
    assign in_key.idx = IDX_W'(i_req.entry_index);

    assign i_req.ready = (r_state == S_IDLE);
    assign req_accept  = i_req.valid && i_req.ready;
    // The response register is a single stage: it takes a new beat when it is empty or
    // when its current beat leaves at the same edge.
    assign commit      = (r_state == S_UPD) && (!r_out_valid || o_rsp.ready);
    assign is_access   = (r_mode == MODE_ACCESS);

    always_comb begin
        cap_wide = CMP_W'(r_cap);
        if (cap_wide == '0) begin
            cap_wide = CMP_W'(1);
        end else if (cap_wide > CMP_W'(ENTRIES)) begin
            cap_wide = CMP_W'(ENTRIES);
        end
    end

    assign lim    = OCC_W'(cap_wide);
    assign lim_m1 = SLOT_W'(lim - OCC_W'(1));
    assign evict  = is_access && !hit && (r_occ >= lim);

    // The row of cells. Slot 0 takes the new key on a miss; every other slot takes its front
    // neighbour. On a hit behind slot 0 the hit slot and the one in front of it swap.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        t_entry prev_data;
        t_entry next_data;
        logic   next_match;
        logic   swap_back;

        if (g == 0) begin : g_first
            assign prev_data = r_key;
            assign swap_back = 1'b0;
        end else begin : g_rest
            assign prev_data = cell_data[g-1];
            assign swap_back = match[g];
        end

        if (g == ENTRIES - 1) begin : g_tail
            assign next_data  = cell_data[g];
            assign next_match = 1'b0;
        end else begin : g_body
            assign next_data  = cell_data[g+1];
            assign next_match = match[g+1];
        end

        assign last_sel[g]           = (lim_m1 == SLOT_W'(g));
        assign cell_ctl[g].cmp_en    = req_accept;
        assign cell_ctl[g].in_use    = (OCC_W'(g) < r_occ);
        assign cell_ctl[g].take_prev = commit && is_access && (!hit || swap_back);
        assign cell_ctl[g].take_next = commit && is_access && hit && next_match;

        tcd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (cell_ctl[g]),
            .i_key   (in_key),
            .i_prev  (prev_data),
            .i_next  (next_data),
            .o_data  (cell_data[g]),
            .o_match (match[g])
        );
    end

    tcd_reduce u_reduce (
        .i_match     (match),
        .i_last      (last_sel),
        .i_data      (cell_data),
        .o_found     (hit),
        .o_slot      (hit_slot),
        .o_last_data (last_data)
    );

    // Occupancy and counters after the item in S_UPD.
    always_comb begin
        n_occ  = r_occ;
        n_reqs = r_reqs;
        n_hits = r_hits;
        unique case (r_mode)
            MODE_ACCESS: begin
                n_reqs = r_reqs + CNT_W'(1);
                if (hit) begin
                    n_hits = r_hits + CNT_W'(1);
                end else if (evict) begin
                    n_occ = lim;
                end else begin
                    n_occ = r_occ + OCC_W'(1);
                end
            end
            MODE_CLEAR: begin
                n_occ  = '0;
                n_reqs = '0;
                n_hits = '0;
            end
            MODE_PROBE, MODE_NONE: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (req_accept) n_state = S_UPD;
            S_UPD:   if (commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_RESET;
            r_occ       <= '0;
            r_reqs      <= '0;
            r_hits      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // The limit only changes while the directory is empty.
            if (i_cfg_we && (r_occ == '0)) begin
                r_cap <= i_cfg_wdata;
            end
            if (commit) begin
                r_occ  <= n_occ;
                r_reqs <= n_reqs;
                r_hits <= n_hits;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request payload and response payload registers.
    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_mode <= t_mode'(i_req.mode);
            r_key  <= in_key;
        end
        if (commit) begin
            r_out_found   <= (is_access || r_mode == MODE_PROBE) && hit;
            r_out_slot    <= ((is_access || r_mode == MODE_PROBE) && hit) ?
                             FSLOT_W'(hit_slot) : '0;
            r_out_ev      <= evict;
            r_out_ev_data <= evict ? last_data : '0;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.found         = r_out_found;
    assign o_rsp.found_slot    = r_out_slot;
    assign o_rsp.evicted       = r_out_ev;
    assign o_rsp.evicted_table = r_out_ev_data.tbl;
    assign o_rsp.evicted_index = FIELD_W'(r_out_ev_data.idx);
    assign o_rsp.requests      = r_reqs;
    assign o_rsp.hits          = r_hits;

    // Keys are unique among the slots in use, so at most one cell may report a match.
    `TCD_ASSERT(a_match_unique, (r_state != S_UPD) || $onehot0(match), "duplicate key in directory")
    // Occupancy never exceeds the effective limit.
    `TCD_ASSERT(a_occ_in_limit, r_occ <= lim, "occupancy beyond the capacity limit")
    // A committed clear leaves the directory empty with both counters at zero.
    `TCD_ASSERT_NEXT(a_clear_empties, commit && (r_mode == MODE_CLEAR),
        (r_occ == '0) && (r_reqs == '0) && (r_hits == '0), "clear did not empty the directory")
    // A committed access always advances the request counter by one.
    `TCD_ASSERT_NEXT(a_req_count, commit && is_access,
        r_reqs == $past(r_reqs) + CNT_W'(1), "request counter did not advance")

endmodule

// ===== tb/sv/transpose_cache_directory_unit_tb.sv =====
// Self-checking testbench for the transpose cache directory top level.
// Needs tcd_pkg and the tcd_req_if / tcd_rsp_if interfaces; compares every
// response beat with a built-in model of the ordered directory or with a typed expectation.
module transpose_cache_directory_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tcd_pkg::*;

    // Far above the slowest legal run: about nine hundred requests, each with
    // its own idle gap, the time spent in the block and the receiver stalls.
    localparam int CYCLE_LIMIT  = 400000;
    // Cycles allowed after the last response for any stray beat to appear.
    localparam int DRAIN_CYCLES = 4;
    localparam int FILL_KEYS    = 520;

    // One response beat as the directory should produce it.
    typedef struct packed {
        logic               found;
        logic [FSLOT_W-1:0] found_slot;
        logic               evicted;
        logic [TABLE_W-1:0] evicted_table;
        logic [FIELD_W-1:0] evicted_index;
        logic [CNT_W-1:0]   requests;
        logic [CNT_W-1:0]   hits;
    } t_dir_rsp;

    typedef enum logic {
        ROW_ITEM,
        ROW_LIMIT
    } t_row_kind;

    // A row of the directed table: either a request beat or a write of the
    // capacity limit (the limit value then sits in data).
    typedef struct {
        t_row_kind          kind;
        t_mode              mode;
        logic [TABLE_W-1:0] tbl;
        logic [FIELD_W-1:0] data;
        bit                 known;
        t_dir_rsp           due;
    } t_dir_row;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_wdata;

    tcd_req_if req_ch ();
    tcd_rsp_if rsp_ch ();

    transpose_cache_directory_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    // Model state: the ordered directory, its fill level, both counters and
    // the capacity limit as last accepted by the block.
    t_entry           dir_slots [ENTRIES];
    int               dir_occ      = 0;
    logic [CNT_W-1:0] dir_requests = '0;
    logic [CNT_W-1:0] dir_hits     = '0;
    logic [CAP_W-1:0] dir_limit    = CAP_RESET;

    t_dir_rsp pending_lookups [$];
    t_dir_row directed_rows [$];

    int send_idle_pct = 31;
    int recv_idle_pct = 69;
    int error_count   = 0;
    int cycle_count   = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Linear search from the front; keys in use are unique, so it finds the one
    // slot that the block's parallel compare reports.
    function automatic bit dir_search(input t_entry key, output int slot);
        int s;
        slot = 0;
        for (s = 0; s < dir_occ; s++) begin
            if (dir_slots[s] == key) begin
                slot = s;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Advances the model by one request and returns the response it should
    // produce. The counters are reported after the update.
    function automatic t_dir_rsp directory_step(input t_mode mode,
                                                input logic [TABLE_W-1:0] tbl,
                                                input logic [FIELD_W-1:0] index);
        t_dir_rsp r;
        t_entry   key;
        t_entry   held;
        int       slot;
        int       lim;
        int       s;
        bit       hit;
        r       = '0;
        key.tbl = tbl;
        key.idx = index[IDX_W-1:0];
        case (mode)
            MODE_ACCESS: begin
                dir_requests++;
                hit = dir_search(key, slot);
                if (hit) begin
                    dir_hits++;
                    r.found      = 1'b1;
                    r.found_slot = FSLOT_W'(slot);
                    // Transpose: a hit behind the front swaps with its neighbour.
                    if (slot > 0) begin
                        held               = dir_slots[slot];
                        dir_slots[slot]    = dir_slots[slot-1];
                        dir_slots[slot-1]  = held;
                    end
                end else begin
                    lim = (dir_limit == 0) ? 1 : (dir_limit > ENTRIES) ? ENTRIES : int'(dir_limit);
                    if (dir_occ >= lim) begin
                        r.evicted       = 1'b1;
                        r.evicted_table = dir_slots[lim-1].tbl;
                        r.evicted_index = FIELD_W'(dir_slots[lim-1].idx);
                        dir_occ         = lim - 1;
                    end
                    for (s = dir_occ; s > 0; s--) dir_slots[s] = dir_slots[s-1];
                    dir_slots[0] = key;
                    dir_occ++;
                end
            end
            MODE_PROBE: begin
                hit = dir_search(key, slot);
                if (hit) begin
                    r.found      = 1'b1;
                    r.found_slot = FSLOT_W'(slot);
                end
            end
            MODE_CLEAR: begin
                dir_occ      = 0;
                dir_requests = '0;
                dir_hits     = '0;
            end
            default: ;
        endcase
        r.requests = dir_requests;
        r.hits     = dir_hits;
        return r;
    endfunction

    function automatic t_dir_rsp rsp(input bit found, input int slot, input bit evicted,
                                     input int ev_tbl, input int ev_idx,
                                     input int requests, input int hits);
        t_dir_rsp r;
        r.found         = found;
        r.found_slot    = FSLOT_W'(slot);
        r.evicted       = evicted;
        r.evicted_table = TABLE_W'(ev_tbl);
        r.evicted_index = FIELD_W'(ev_idx);
        r.requests      = CNT_W'(requests);
        r.hits          = CNT_W'(hits);
        return r;
    endfunction

    function automatic void add_row(input t_row_kind kind, input t_mode mode, input int tbl,
                                    input int data, input bit known, input t_dir_rsp due);
        t_dir_row row;
        row.kind  = kind;
        row.mode  = mode;
        row.tbl   = TABLE_W'(tbl);
        row.data  = FIELD_W'(data);
        row.known = known;
        row.due   = due;
        directed_rows = {directed_rows, row};
    endfunction

    // Presents one request beat. Called at a falling edge and returns at a
    // falling edge with valid low, so a following call may raise it again in
    // the same step without the block ever seeing the dip.
    task automatic send_item(input t_mode mode, input logic [TABLE_W-1:0] tbl,
                             input logic [FIELD_W-1:0] index, input bit known,
                             input t_dir_rsp typed);
        t_dir_rsp predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid       = 1'b1;
        req_ch.mode        = mode;
        req_ch.table_id    = tbl;
        req_ch.entry_index = index;
        do @(posedge clk); while (!req_ch.ready);
        predicted = directory_step(mode, tbl, index);
        if (known) predicted = typed;
        pending_lookups = {pending_lookups, predicted};
        @(negedge clk);
        req_ch.valid = 1'b0;
    endtask

    // The limit may only be written with the block idle: every response in
    // flight has come back first. The block keeps the old limit unless the
    // directory is empty, and so does the model.
    task automatic write_limit(input logic [CAP_W-1:0] value);
        while (pending_lookups.size() != 0) @(posedge clk);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        if (dir_occ == 0) dir_limit = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Clears, sets a limit, then sends random requests drawn mostly from a
    // small pool of keys so that hits, swaps and evictions all occur often.
    task automatic run_random_phase(input logic [CAP_W-1:0] limit, input int count,
                                    input int pool_size);
        t_entry pool [32];
        t_entry key;
        t_mode  mode;
        int     n;
        int     r;
        for (n = 0; n < pool_size; n++) begin
            pool[n].tbl = TABLE_W'($urandom_range(0, 7));
            pool[n].idx = IDX_W'($urandom);
        end
        pool[0].tbl = '1;
        pool[0].idx = '1;
        send_item(MODE_CLEAR, '0, '0, 1'b0, '0);
        write_limit(limit);
        for (n = 0; n < count; n++) begin
            r    = $urandom_range(0, 99);
            mode = (r < 70) ? MODE_ACCESS : (r < 92) ? MODE_PROBE :
                   (r < 97) ? MODE_NONE : MODE_CLEAR;
            if ($urandom_range(0, 4) == 0) begin
                key.tbl = TABLE_W'($urandom_range(0, 7));
                key.idx = IDX_W'($urandom);
            end else begin
                key = pool[$urandom_range(0, pool_size - 1)];
            end
            send_item(mode, key.tbl, FIELD_W'(key.idx), 1'b0, '0);
        end
    endtask

    // Receiver: ready is redrawn at every falling edge.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            rsp_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Response checker: each accepted beat is matched against the oldest
    // outstanding expectation, field by field.
    always @(posedge clk) begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin : check_beat
            t_dir_rsp due;
            if (pending_lookups.size() == 0) begin
                $error("response beat with no request outstanding");
                error_count++;
            end else begin
                due = pending_lookups.pop_front();
                if (rsp_ch.found !== due.found) begin
                    $error("found: expected %0d, got %0d", due.found, rsp_ch.found);
                    error_count++;
                end
                if (rsp_ch.found_slot !== due.found_slot) begin
                    $error("found_slot: expected %0d, got %0d", due.found_slot,
                           rsp_ch.found_slot);
                    error_count++;
                end
                if (rsp_ch.evicted !== due.evicted) begin
                    $error("evicted: expected %0d, got %0d", due.evicted, rsp_ch.evicted);
                    error_count++;
                end
                if (rsp_ch.evicted_table !== due.evicted_table) begin
                    $error("evicted_table: expected %0d, got %0d", due.evicted_table,
                           rsp_ch.evicted_table);
                    error_count++;
                end
                if (rsp_ch.evicted_index !== due.evicted_index) begin
                    $error("evicted_index: expected 0x%06h, got 0x%06h", due.evicted_index,
                           rsp_ch.evicted_index);
                    error_count++;
                end
                if (rsp_ch.requests !== due.requests) begin
                    $error("requests: expected %0d, got %0d", due.requests, rsp_ch.requests);
                    error_count++;
                end
                if (rsp_ch.hits !== due.hits) begin
                    $error("hits: expected %0d, got %0d", due.hits, rsp_ch.hits);
                    error_count++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        t_entry fill_keys [FILL_KEYS];
        t_entry key;
        int     k;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        req_ch.valid       = 1'b0;
        req_ch.mode        = MODE_ACCESS;
        req_ch.table_id    = '0;
        req_ch.entry_index = '0;

        // Directed table. Rows with a typed response follow by hand from the
        // order of the directory; the rest are left to the model.
        // Keys: A = (0, 0), B = (7, all ones), C = (0, all ones), D = (7, 0).
        add_row(ROW_ITEM, MODE_ACCESS, 0, 0, 1, rsp(0, 0, 0, 0, 0, 1, 0));
        add_row(ROW_ITEM, MODE_ACCESS, 7, 'hFFFFFF, 1, rsp(0, 0, 0, 0, 0, 2, 0));
        // A hit one slot back moves A to the front.
        add_row(ROW_ITEM, MODE_ACCESS, 0, 0, 1, rsp(1, 1, 0, 0, 0, 3, 1));
        // A hit at the front leaves the order alone.
        add_row(ROW_ITEM, MODE_ACCESS, 0, 0, 1, rsp(1, 0, 0, 0, 0, 4, 2));
        // A probe reports but neither counts nor moves anything.
        add_row(ROW_ITEM, MODE_PROBE, 7, 'hFFFFFF, 1, rsp(1, 1, 0, 0, 0, 4, 2));
        add_row(ROW_ITEM, MODE_PROBE, 3, 'h123456, 1, rsp(0, 0, 0, 0, 0, 4, 2));
        // The unused mode does nothing and reports the counters unchanged.
        add_row(ROW_ITEM, MODE_NONE, 5, 'hABCDEF, 1, rsp(0, 0, 0, 0, 0, 4, 2));
        // Same index in another table, same table with another index: both miss.
        add_row(ROW_ITEM, MODE_ACCESS, 0, 'hFFFFFF, 1, rsp(0, 0, 0, 0, 0, 5, 2));
        add_row(ROW_ITEM, MODE_ACCESS, 7, 0, 1, rsp(0, 0, 0, 0, 0, 6, 2));
        add_row(ROW_ITEM, MODE_PROBE, 7, 'hFFFFFF, 1, rsp(1, 3, 0, 0, 0, 6, 2));
        add_row(ROW_ITEM, MODE_CLEAR, 6, 'h0F0F0F, 1, rsp(0, 0, 0, 0, 0, 0, 0));
        add_row(ROW_ITEM, MODE_PROBE, 0, 0, 1, rsp(0, 0, 0, 0, 0, 0, 0));
        add_row(ROW_ITEM, MODE_ACCESS, 2, 'h555555, 1, rsp(0, 0, 0, 0, 0, 1, 0));
        add_row(ROW_ITEM, MODE_ACCESS, 5, 'hAAAAAA, 0, '0);
        // A limit write with entries present must be ignored: the next miss
        // still finds room and evicts nothing.
        add_row(ROW_LIMIT, MODE_ACCESS, 0, 0, 0, '0);
        add_row(ROW_ITEM, MODE_ACCESS, 4, 'h000FFF, 1, rsp(0, 0, 0, 0, 0, 3, 0));
        add_row(ROW_ITEM, MODE_ACCESS, 2, 'h555555, 1, rsp(1, 2, 0, 0, 0, 4, 1));
        add_row(ROW_ITEM, MODE_CLEAR, 0, 0, 1, rsp(0, 0, 0, 0, 0, 0, 0));
        // A limit of zero acts as one: the second key pushes the first out.
        add_row(ROW_LIMIT, MODE_ACCESS, 0, 0, 0, '0);
        add_row(ROW_ITEM, MODE_ACCESS, 1, 'h000001, 1, rsp(0, 0, 0, 0, 0, 1, 0));
        add_row(ROW_ITEM, MODE_ACCESS, 6, 'h800000, 1, rsp(0, 0, 1, 1, 'h000001, 2, 0));
        add_row(ROW_ITEM, MODE_PROBE, 1, 'h000001, 1, rsp(0, 0, 0, 0, 0, 2, 0));
        add_row(ROW_ITEM, MODE_ACCESS, 6, 'h800000, 1, rsp(1, 0, 0, 0, 0, 3, 1));
        add_row(ROW_ITEM, MODE_CLEAR, 0, 0, 1, rsp(0, 0, 0, 0, 0, 0, 0));
        // The largest register value is clamped to the directory size.
        add_row(ROW_LIMIT, MODE_ACCESS, 0, 1023, 0, '0);
        add_row(ROW_ITEM, MODE_ACCESS, 3, 'h3C3C3C, 0, '0);

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Sender idles less than the receiver for the first stretch.
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_LIMIT) begin
                write_limit(directed_rows[i].data[CAP_W-1:0]);
            end else begin
                send_item(directed_rows[i].mode, directed_rows[i].tbl, directed_rows[i].data,
                          directed_rows[i].known, directed_rows[i].due);
            end
        end
        run_random_phase(CAP_W'(2), 80, 4);
        run_random_phase(CAP_W'(8), 100, 12);

        // Roles swapped: the sender now idles more than the receiver.
        send_idle_pct = 69;
        recv_idle_pct = 31;
        run_random_phase(CAP_W'($urandom_range(3, 40)), 80, 24);

        // Fill the whole directory with distinct keys (the low ten index bits
        // carry a running count) and go past it, so that evictions happen at
        // the last slot and hits reach the deepest slot numbers.
        send_item(MODE_CLEAR, '0, '0, 1'b0, '0);
        write_limit(CAP_W'(ENTRIES));
        for (k = 0; k < FILL_KEYS; k++) begin
            fill_keys[k].tbl = TABLE_W'($urandom_range(0, 7));
            fill_keys[k].idx = {(IDX_W - 10)'($urandom), 10'(k)};
            send_item(MODE_ACCESS, fill_keys[k].tbl, FIELD_W'(fill_keys[k].idx), 1'b0, '0);
        end
        // The oldest survivor sits in the last slot; the one before it is gone.
        send_item(MODE_PROBE, fill_keys[8].tbl, FIELD_W'(fill_keys[8].idx), 1'b0, '0);
        send_item(MODE_ACCESS, fill_keys[8].tbl, FIELD_W'(fill_keys[8].idx), 1'b0, '0);
        send_item(MODE_ACCESS, fill_keys[7].tbl, FIELD_W'(fill_keys[7].idx), 1'b0, '0);
        for (k = 0; k < 40; k++) begin
            key = fill_keys[$urandom_range(0, FILL_KEYS - 1)];
            send_item($urandom_range(0, 1) ? MODE_PROBE : MODE_ACCESS, key.tbl,
                      FIELD_W'(key.idx), 1'b0, '0);
        end

        // No idling on either side, with an over-range limit that clamps.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(CAP_W'($urandom_range(513, 1023)), 48, 30);

        while (pending_lookups.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
